// ----- rtl/core/hpg_pkg.sv -----
// shared types, constants and arithmetic helpers for the gradient panel pixel pipeline
`timescale 1ns / 1ps

package hpg_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned HUE_W   = 9;
  localparam int unsigned SEG_W   = 3;
  localparam int unsigned RAD_W   = 18;   // squared radius, padded to an even bit count
  localparam int unsigned REM_W   = 11;
  localparam int unsigned ROOT_W  = 9;
  localparam int unsigned STEPS_PER_STAGE = 3;
  localparam int unsigned SQRT_STAGES     = 3;

  localparam logic [COORD_W-1:0] FULL = 8'd255;

  // segment codes
  localparam logic [SEG_W-1:0] SEG_0 = 3'd0;
  localparam logic [SEG_W-1:0] SEG_1 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_3 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_4 = 3'd4;
  localparam logic [SEG_W-1:0] SEG_5 = 3'd5;

  // digit-by-digit square root working state
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [COORD_W-1:0] red;
    logic [COORD_W-1:0] green;
    logic [COORD_W-1:0] blue;
  } rgb_t;

  // exact floor(v / 255) for any 16-bit v below 65280, where the quotient fits in eight bits
  function automatic logic [COORD_W-1:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return s[15:8];
  endfunction

  // three result bits of the square root
  function automatic sqrt_t sqrt_steps(input sqrt_t s_in);
    sqrt_t       s;
    logic [12:0] rem_s;
    logic [12:0] trial;
    s = s_in;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      rem_s = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      s.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem_s  = rem_s - trial;
        s.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        s.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      s.rem = rem_s[REM_W-1:0];
    end
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] clamp255(input logic [ROOT_W:0] v);
    return (v > {2'b00, FULL}) ? FULL : v[COORD_W-1:0];
  endfunction

  // per-segment channel routing of 255-z, 255-t, 255-y
  function automatic rgb_t route(input logic [SEG_W-1:0] seg, input logic [COORD_W-1:0] z,
                                 input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] y);
    rgb_t c;
    logic [COORD_W-1:0] iz, it, iy;
    iz = FULL - z;
    it = FULL - t;
    iy = FULL - y;
    c  = '0;
    case (seg)
      SEG_0: begin c.blue = iz; c.green = it; c.red = iy; end
      SEG_1: begin c.blue = iz; c.green = iy; c.red = it; end
      SEG_2: begin c.blue = it; c.green = iy; c.red = iz; end
      SEG_3: begin c.blue = iy; c.green = it; c.red = iz; end
      SEG_4: begin c.blue = iy; c.green = iz; c.red = it; end
      SEG_5: begin c.blue = it; c.green = iz; c.red = iy; end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/hue_panel_gradient_pixel_top.sv -----
// gradient panel pixel generator: eight-stage pipeline from coordinates to color
`timescale 1ns / 1ps

// Takes one pixel (pixel_x, pixel_y) per clock whenever start is high and returns its
// color on red/green/blue from the output register, marked by a one-cycle done strobe.
// busy stays low: the pipeline has no stall point, the receiver cannot hold results off,
// and every word in flight comes out in order. Stages: products, radius sum with the divide by
// 255, scaled square, second sum, three square root stages of three bits each, color
// routing. hue_position is written by hue_write and sets the segment and ramp; write it
// only when no pixel is in flight. Positions 384 and above give black.
module hue_panel_gradient_pixel_top import hpg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [COORD_W-1:0]  pixel_x,
  input  logic [COORD_W-1:0]  pixel_y,
  input  logic                hue_write,
  input  logic [HUE_W-1:0]    hue_position,
  output logic                done,
  output logic [COORD_W-1:0]  red,
  output logic [COORD_W-1:0]  green,
  output logic [COORD_W-1:0]  blue
);

  logic [HUE_W-1:0] hue;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hue <= '0;
    end else if (hue_write) begin
      hue <= hue_position;
    end
  end

  assign busy = 1'b0;

  // scale factor: 255-p on even segments, p on odd ones
  logic [COORD_W-1:0] ramp;
  logic [COORD_W-1:0] scale;
  assign ramp  = {hue[5:0], 2'b00};
  assign scale = hue[6] ? ramp : (FULL - ramp);

  // valid bits
  logic v1, v2, v3, v4, v7;
  logic [SQRT_STAGES-1:0] vs;

  // stage 1: products
  logic [15:0]        xx1, yy1, prod1;
  logic [COORD_W-1:0] y1;
  logic [SEG_W-1:0]   seg1;
  always_ff @(posedge clk) begin
    xx1   <= {8'd0, pixel_x} * {8'd0, pixel_x};
    yy1   <= {8'd0, pixel_y} * {8'd0, pixel_y};
    prod1 <= {8'd0, pixel_x} * {8'd0, scale};
    y1    <= pixel_y;
    seg1  <= hue[HUE_W-1 -: SEG_W];
  end

  // stage 2: radius sum and divide by 255
  logic [16:0]        nz2;
  logic [15:0]        yy2;
  logic [COORD_W-1:0] a2, y2;
  logic [SEG_W-1:0]   seg2;
  always_ff @(posedge clk) begin
    nz2  <= {1'b0, xx1} + {1'b0, yy1};
    a2   <= div255(prod1);
    yy2  <= yy1;
    y2   <= y1;
    seg2 <= seg1;
  end

  // stage 3: square of scaled coordinate
  logic [16:0]        nz3;
  logic [15:0]        yy3, aa3;
  logic [COORD_W-1:0] y3;
  logic [SEG_W-1:0]   seg3;
  always_ff @(posedge clk) begin
    aa3  <= {8'd0, a2} * {8'd0, a2};
    nz3  <= nz2;
    yy3  <= yy2;
    y3   <= y2;
    seg3 <= seg2;
  end

  // stage 4: second radius sum, load both roots
  sqrt_t              sz4, st4;
  logic [COORD_W-1:0] y4;
  logic [SEG_W-1:0]   seg4;
  always_ff @(posedge clk) begin
    sz4  <= '{rad: {1'b0, nz3}, rem: '0, root: '0};
    st4  <= '{rad: {1'b0, {1'b0, aa3} + {1'b0, yy3}}, rem: '0, root: '0};
    y4   <= y3;
    seg4 <= seg3;
  end

  // stages 5 to 7: square root, three bits per stage on both radii
  sqrt_t              sz [SQRT_STAGES];
  sqrt_t              st [SQRT_STAGES];
  logic [COORD_W-1:0] ys [SQRT_STAGES];
  logic [SEG_W-1:0]   segs [SQRT_STAGES];
  always_ff @(posedge clk) begin
    sz[0]   <= sqrt_steps(sz4);
    st[0]   <= sqrt_steps(st4);
    ys[0]   <= y4;
    segs[0] <= seg4;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sz[i]   <= sqrt_steps(sz[i-1]);
      st[i]   <= sqrt_steps(st[i-1]);
      ys[i]   <= ys[i-1];
      segs[i] <= segs[i-1];
    end
  end

  // stage 8: floor root for z, ceiling root for t, clamp and route
  logic [ROOT_W:0] t_ceil;
  rgb_t            color;
  assign t_ceil = {1'b0, st[SQRT_STAGES-1].root}
                + {{ROOT_W{1'b0}}, (st[SQRT_STAGES-1].rem != '0)};
  assign color  = route(segs[SQRT_STAGES-1],
                        clamp255({1'b0, sz[SQRT_STAGES-1].root}),
                        clamp255(t_ceil), ys[SQRT_STAGES-1]);

  always_ff @(posedge clk) begin
    red   <= color.red;
    green <= color.green;
    blue  <= color.blue;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vs   <= '0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      vs   <= {vs[SQRT_STAGES-2:0], v4};
      done <= v7;
    end
  end
  assign v7 = vs[SQRT_STAGES-1];

`ifndef SYNTH
  // every accepted word comes out as a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##8 done)
    else $error("pixel word lost in pipeline");

  // no result without a matching accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 8))
    else $error("spurious result word");

  // out-of-range segments give black
  a_black: assert property (@(posedge clk) disable iff (rst)
      (v7 && segs[SQRT_STAGES-1][2:1] == 2'b11) |=> (red == '0 && green == '0 && blue == '0))
    else $error("out-of-range hue not black");

  // pipeline never stalls the sender
  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
`endif

endmodule
